// ===== rtl/core/ust_pkg.sv =====
// Shared types and constants for the unordered set table.
`timescale 1ns / 1ps

package ust_pkg;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 8;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // capture a new request and restart the scan
        logic rd_scan;    // read the entry at the scan index
        logic rd_shift;   // read the entry just above the scan index
        logic wr_shift;   // write the shifted entry at the scan index
        logic wr_append;  // write the request value at the end of the table
        logic inc_idx;
        logic set_found;
        logic set_reject;
        logic inc_count;
        logic dec_count;
        logic load_out;   // move the finished result into the output register
    } ust_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic match;      // read data equals the request value
        logic last;       // scan index is the last valid entry
        logic full;
        logic op_insert;
        logic op_erase;
    } ust_status_t;

endpackage

// ===== rtl/core/ust_datapath.sv =====
// Datapath of the set table: entry memory, scan index, fill count and result register.
`timescale 1ns / 1ps

module ust_datapath #(
    parameter int CAPACITY = 128
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ust_pkg::ust_cmd_t                cmd,
    output ust_pkg::ust_status_t             status,
    input  logic [ust_pkg::OP_W-1:0]         opcode,
    input  logic signed [ust_pkg::VALUE_W-1:0] value,
    output logic                             found,
    output logic [ust_pkg::COUNT_W-1:0]      element_count,
    output logic                             full_reject
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int EXT_W = CW + ust_pkg::COUNT_W;

    logic [ust_pkg::VALUE_W-1:0] mem [CAPACITY];

    logic [ust_pkg::OP_W-1:0]    opcode_reg;
    logic [ust_pkg::VALUE_W-1:0] value_reg;
    logic [ust_pkg::VALUE_W-1:0] rd_data_reg;
    logic [CW-1:0]               idx_reg;
    logic [CW-1:0]               idx_next;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic                        found_reg;
    logic                        reject_reg;
    logic                        out_found_reg;
    logic [ust_pkg::COUNT_W-1:0] out_count_reg;
    logic                        out_reject_reg;

    logic [CW-1:0]               idx_plus1;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic [ust_pkg::VALUE_W-1:0] wr_data;
    logic                        wr_en;
    logic [EXT_W-1:0]            count_ext;

    assign idx_plus1 = idx_reg + 1'b1;
    assign rd_addr   = cmd.rd_shift ? idx_plus1[AW-1:0] : idx_reg[AW-1:0];
    assign wr_addr   = cmd.wr_append ? count_reg[AW-1:0] : idx_reg[AW-1:0];
    assign wr_data   = cmd.wr_append ? value_reg : rd_data_reg;
    assign wr_en     = cmd.wr_append | cmd.wr_shift;
    assign count_ext = EXT_W'(count_reg);

    always_comb
    begin
        status.count_zero = (count_reg == '0);
        status.match      = (rd_data_reg == value_reg);
        status.last       = (idx_plus1 == count_reg);
        status.full       = (count_reg == CW'(CAPACITY));
        status.op_insert  = (opcode_reg == ust_pkg::OP_INSERT);
        status.op_erase   = (opcode_reg == ust_pkg::OP_ERASE);
    end

    // Entry memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_scan || cmd.rd_shift)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.accept)
        begin
            idx_next = '0;
        end
        else if (cmd.inc_idx)
        begin
            idx_next = idx_plus1;
        end

        count_next = count_reg;
        if (cmd.inc_count)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.dec_count)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.accept)
        begin
            opcode_reg <= opcode;
            value_reg  <= value;
            found_reg  <= 1'b0;
            reject_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_found)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.set_reject)
            begin
                reject_reg <= 1'b1;
            end
        end
        if (cmd.load_out)
        begin
            out_found_reg  <= found_reg;
            out_count_reg  <= count_ext[ust_pkg::COUNT_W-1:0];
            out_reject_reg <= reject_reg;
        end
    end

    assign found         = out_found_reg;
    assign element_count = out_count_reg;
    assign full_reject   = out_reject_reg;

endmodule

// ===== rtl/core/ust_ctrl.sv =====
// Controller of the set table: sequences the scan, the append and the erase shift.
`timescale 1ns / 1ps

module ust_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  ust_pkg::ust_status_t status,
    output ust_pkg::ust_cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_READ     = 7'b0000010,
        S_CMP      = 7'b0000100,
        S_MISS     = 7'b0001000,
        S_SHIFT_RD = 7'b0010000,
        S_SHIFT_WR = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.count_zero ? S_MISS : S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                if (status.match)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = status.op_erase ? S_SHIFT_RD : S_DONE;
                end
                else if (status.last)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    cmd.inc_idx = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_MISS:
            begin
                if (status.op_insert)
                begin
                    if (status.full)
                    begin
                        cmd.set_reject = 1'b1;
                    end
                    else
                    begin
                        cmd.wr_append = 1'b1;
                        cmd.inc_count = 1'b1;
                    end
                end
                state_next = S_DONE;
            end
            S_SHIFT_RD:
            begin
                // The removed slot has reached the top of the table once the index is last.
                if (status.last)
                begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.rd_shift = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.inc_idx  = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/unordered_set_table_unit.sv =====
// Top level of the unordered set table: controller plus datapath.
//
//   Channel   Signals                                   Direction
//   in        in_valid, in_ready, opcode, value         request into the block
//   out       out_valid, out_ready, found,              result out of the block
//             element_count, full_reject
//
// Each scanned entry is read from the memory and then compared; a miss goes on to an append
// when the request is an insert and the table is not full, and an erase hit moves every entry
// above the removed slot down by one, each with a read and then a write, through the registered read.
// Reset empties the set at once; the entry memory is not cleared.
// A new request is taken while the previous result still waits in the output register;
// a finished request holds until that register is free.
`timescale 1ns / 1ps

module unordered_set_table_unit #(
    parameter int CAPACITY = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ust_pkg::OP_W-1:0]           opcode,
    input  logic signed [ust_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               found,
    output logic [ust_pkg::COUNT_W-1:0]        element_count,
    output logic                               full_reject
);

    ust_pkg::ust_cmd_t    cmd;
    ust_pkg::ust_status_t status;

    ust_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ust_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .opcode        (opcode),
        .value         (value),
        .found         (found),
        .element_count (element_count),
        .full_reject   (full_reject)
    );

endmodule

// ===== rtl/core/ust_checker.sv =====
// Port-level assertions for the unordered set table, bound to the top level.
`timescale 1ns / 1ps

module ust_checker #(
    parameter int CAPACITY = 128
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [ust_pkg::OP_W-1:0]           opcode,
    input logic signed [ust_pkg::VALUE_W-1:0] value,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic                               found,
    input logic [ust_pkg::COUNT_W-1:0]        element_count,
    input logic                               full_reject
);

    localparam int EXT_W = 32 + ust_pkg::COUNT_W;
    localparam logic [EXT_W-1:0] CAP_EXT = EXT_W'(CAPACITY);
    localparam logic [ust_pkg::COUNT_W-1:0] CAP_LOW = CAP_EXT[ust_pkg::COUNT_W-1:0];

    // A waiting request keeps its fields until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(opcode) && $stable(value))
        else $error("request changed while waiting");

    // A stalled result keeps its fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found)
            && $stable(element_count) && $stable(full_reject))
        else $error("result changed while stalled");

    // Only one request is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in work");

    // A refused insert means the value was absent.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_reject |-> !found)
        else $error("full reject with value present");

    // A refused insert happens only with a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && full_reject |-> element_count == CAP_LOW)
        else $error("full reject while table not full");

endmodule

bind unordered_set_table_unit ust_checker #(
    .CAPACITY (CAPACITY)
) u_ust_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .found         (found),
    .element_count (element_count),
    .full_reject   (full_reject)
);
